@@ design/rpn_pkg.sv @@
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types, codes and defaults for the reverse Polish stack calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

	localparam int DATA_W              = 64;
	localparam int OP_W                = 3;
	localparam int STATUS_W            = 3;
	localparam int DEPTH_W             = 7;
	localparam int COMMIT_W            = 3;
	localparam int STACK_DEPTH_DEF     = 64;
	localparam int FRACTION_BITS_DEF   = 32;

	localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
	localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
	localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
	localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
	localparam logic [OP_W-1:0] OP_DROP = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FEW      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

	localparam logic [COMMIT_W-1:0] CM_NONE = 3'd0;
	localparam logic [COMMIT_W-1:0] CM_PUSH = 3'd1;
	localparam logic [COMMIT_W-1:0] CM_DROP = 3'd2;
	localparam logic [COMMIT_W-1:0] CM_ADD  = 3'd3;
	localparam logic [COMMIT_W-1:0] CM_SUB  = 3'd4;
	localparam logic [COMMIT_W-1:0] CM_MUL  = 3'd5;
	localparam logic [COMMIT_W-1:0] CM_DIV  = 3'd6;

	typedef struct packed {
		logic [OP_W-1:0]          operation;
		logic signed [DATA_W-1:0] push_value;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic signed [DATA_W-1:0] top_value;
		logic [DEPTH_W-1:0]       depth;
	} result_t;

	typedef struct packed {
		logic                  load;
		logic                  mul_start;
		logic                  mul_step;
		logic                  div_start;
		logic                  div_step;
		logic [COMMIT_W-1:0]   commit;
		logic [STATUS_W-1:0]   status;
		logic                  report;
	} dp_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            empty;
		logic            few;
		logic            full;
		logic            y_zero;
		logic            mul_done;
		logic            div_done;
	} dp_stat_t;

endpackage

@@ design/rpn_ctrl.sv @@
// ----------------------------------------------------------------------------
// rpn_ctrl
// Sequencer: accepts a request, checks the operands and drives the datapath.
// ----------------------------------------------------------------------------
module rpn_ctrl import rpn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output logic     busy,
	output dp_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d    = S_IDLE;
				cmd.report = 1'b1;
				cmd.status = ST_OK;
				cmd.commit = CM_NONE;
				unique case (stat.op)
					OP_PUSH: begin
						if (stat.full) cmd.status = ST_FULL;
						else cmd.commit = CM_PUSH;
					end
					OP_DROP: begin
						if (stat.empty) cmd.status = ST_EMPTY;
						else cmd.commit = CM_DROP;
					end
					OP_ADD: begin
						if (stat.few) cmd.status = ST_FEW;
						else cmd.commit = CM_ADD;
					end
					OP_SUB: begin
						if (stat.few) cmd.status = ST_FEW;
						else cmd.commit = CM_SUB;
					end
					OP_MUL: begin
						if (stat.few) begin
							cmd.status = ST_FEW;
						end else begin
							cmd.report    = 1'b0;
							cmd.mul_start = 1'b1;
							state_d       = S_MUL;
						end
					end
					OP_DIV: begin
						priority if (stat.few) begin
							cmd.status = ST_FEW;
						end else if (stat.y_zero) begin
							cmd.status = ST_DIV_ZERO;
						end else begin
							cmd.report    = 1'b0;
							cmd.div_start = 1'b1;
							state_d       = S_DIV;
						end
					end
					default: begin
						cmd.status = ST_OK;
					end
				endcase
			end
			S_MUL: begin
				if (stat.mul_done) begin
					cmd.commit = CM_MUL;
					cmd.status = ST_OK;
					cmd.report = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.mul_step = 1'b1;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					cmd.commit = CM_DIV;
					cmd.status = ST_OK;
					cmd.report = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ design/rpn_dp.sv @@
// ----------------------------------------------------------------------------
// rpn_dp
// Datapath: operand stack with a top register, multi-cycle multiplier,
// radix-2 divider and the result register.
// ----------------------------------------------------------------------------
module rpn_dp import rpn_pkg::*; #(
	parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  request_t request,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	output logic     done,
	output result_t  result
);

	localparam int AW        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW        = $clog2(STACK_DEPTH + 1);
	localparam int NUM_W     = DATA_W + FRACTION_BITS;
	localparam int DCW       = $clog2(NUM_W + 1);
	localparam int MUL_STEPS = 5;
	localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
		return v[DATA_W-1] ? (-v) : v;
	endfunction

	function automatic logic [DATA_W-1:0] sat_result(input logic neg,
			input logic [2*DATA_W-1:0] m);
		logic [DATA_W-1:0] limit;
		limit = neg ? DATA_MIN : DATA_MAX;
		if ((m[2*DATA_W-1:DATA_W] != '0) || (m[DATA_W-1:0] > limit)) begin
			return limit;
		end
		return neg ? (-m[DATA_W-1:0]) : m[DATA_W-1:0];
	endfunction

	function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b);
		logic [DATA_W-1:0] s;
		s = a + b;
		if ((a[DATA_W-1] == b[DATA_W-1]) && (s[DATA_W-1] != a[DATA_W-1])) begin
			return a[DATA_W-1] ? DATA_MIN : DATA_MAX;
		end
		return s;
	endfunction

	function automatic logic [DATA_W-1:0] sat_sub(input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b);
		logic [DATA_W-1:0] s;
		s = a - b;
		if ((a[DATA_W-1] != b[DATA_W-1]) && (s[DATA_W-1] != a[DATA_W-1])) begin
			return a[DATA_W-1] ? DATA_MIN : DATA_MAX;
		end
		return s;
	endfunction

	logic [DATA_W-1:0] stack_q [STACK_DEPTH];
	logic [DATA_W-1:0] rd_q;
	logic [DATA_W-1:0] top_q;
	logic [CW-1:0]     count_q;
	logic [OP_W-1:0]   op_q;
	logic [DATA_W-1:0] val_q;
	logic              done_q;
	result_t           res_q;

	logic [CW-1:0]     cnt_m1;
	logic [CW-1:0]     cnt_m2;
	logic [CW-1:0]     next_count;
	logic [DATA_W-1:0] next_top;
	logic              wr_en;

	logic [DATA_W-1:0]   ma_q;
	logic [DATA_W-1:0]   mb_q;
	logic                neg_q;
	logic [DATA_W-1:0]   pp_q;
	logic [1:0]          pp_sh_q;
	logic [2*DATA_W-1:0] acc_q;
	logic [2:0]          mcnt_q;
	logic [2*DATA_W-1:0] pp_ext;
	logic [2*DATA_W-1:0] mul_mag;

	logic [NUM_W-1:0]  dn_q;
	logic [NUM_W-1:0]  dq_q;
	logic [DATA_W-1:0] dr_q;
	logic [DCW-1:0]    dcnt_q;
	logic [DATA_W:0]   d_shift;
	logic [DATA_W:0]   d_diff;
	logic              d_ge;

	assign cnt_m1 = count_q - CW'(1);
	assign cnt_m2 = count_q - CW'(2);

	assign stat.op       = op_q;
	assign stat.empty    = (count_q == '0);
	assign stat.few      = (count_q < CW'(2));
	assign stat.full     = (count_q == CW'(STACK_DEPTH));
	assign stat.y_zero   = (top_q == '0);
	assign stat.mul_done = (mcnt_q == 3'(MUL_STEPS));
	assign stat.div_done = (dcnt_q == DCW'(NUM_W));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= request.operation;
			val_q <= request.push_value;
		end
		rd_q <= stack_q[cnt_m2[AW-1:0]];
		if (wr_en) begin
			stack_q[cnt_m1[AW-1:0]] <= top_q;
		end
		top_q <= next_top;
	end

	assign wr_en = (cmd.commit == CM_PUSH) && (count_q != '0);

	assign mul_mag = acc_q >> FRACTION_BITS;

	always_comb begin
		next_count = count_q;
		next_top   = top_q;
		unique case (cmd.commit)
			CM_PUSH: begin
				next_count = count_q + CW'(1);
				next_top   = val_q;
			end
			CM_DROP: begin
				next_count = cnt_m1;
				next_top   = rd_q;
			end
			CM_ADD: begin
				next_count = cnt_m1;
				next_top   = sat_add(rd_q, top_q);
			end
			CM_SUB: begin
				next_count = cnt_m1;
				next_top   = sat_sub(rd_q, top_q);
			end
			CM_MUL: begin
				next_count = cnt_m1;
				next_top   = sat_result(neg_q, mul_mag);
			end
			CM_DIV: begin
				next_count = cnt_m1;
				next_top   = sat_result(neg_q, (2*DATA_W)'(dq_q));
			end
			default: begin
				next_count = count_q;
				next_top   = top_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= next_count;
			done_q  <= cmd.report;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.report) begin
			res_q.status    <= cmd.status;
			res_q.top_value <= (next_count == '0) ? '0 : next_top;
			res_q.depth     <= DEPTH_W'(next_count);
		end
	end

	assign done   = done_q;
	assign result = res_q;

	// The four 32x32 partial products are formed one per cycle, each registered
	// and added into the accumulator in the cycle after.
	always_comb begin
		unique case (pp_sh_q)
			2'd0:    pp_ext = {{DATA_W{1'b0}}, pp_q};
			2'd1:    pp_ext = {{(DATA_W/2){1'b0}}, pp_q, {(DATA_W/2){1'b0}}};
			default: pp_ext = {pp_q, {DATA_W{1'b0}}};
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start || cmd.div_start) begin
			ma_q  <= mag(rd_q);
			mb_q  <= mag(top_q);
			neg_q <= rd_q[DATA_W-1] ^ top_q[DATA_W-1];
		end
		if (cmd.mul_start) begin
			acc_q <= '0;
		end else if (cmd.mul_step && (mcnt_q != 3'(MUL_STEPS))) begin
			if (mcnt_q < 3'd4) begin
				pp_q <= (mcnt_q[1] ? DATA_W'(ma_q[DATA_W-1:DATA_W/2])
						: DATA_W'(ma_q[DATA_W/2-1:0]))
					* (mcnt_q[0] ? DATA_W'(mb_q[DATA_W-1:DATA_W/2])
						: DATA_W'(mb_q[DATA_W/2-1:0]));
				pp_sh_q <= {1'b0, mcnt_q[1]} + {1'b0, mcnt_q[0]};
			end
			if (mcnt_q != '0) begin
				acc_q <= acc_q + pp_ext;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q <= '0;
			dcnt_q <= '0;
		end else begin
			if (cmd.mul_start) begin
				mcnt_q <= '0;
			end else if (cmd.mul_step && (mcnt_q != 3'(MUL_STEPS))) begin
				mcnt_q <= mcnt_q + 3'd1;
			end
			if (cmd.div_start) begin
				dcnt_q <= '0;
			end else if (cmd.div_step && !stat.div_done) begin
				dcnt_q <= dcnt_q + DCW'(1);
			end
		end
	end

	// Restoring division, one quotient bit per cycle, most significant first.
	assign d_shift = {dr_q, dn_q[NUM_W-1]};
	assign d_ge    = (d_shift >= {1'b0, mb_q});
	assign d_diff  = d_shift - {1'b0, mb_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dn_q <= NUM_W'(mag(rd_q)) << FRACTION_BITS;
			dq_q <= '0;
			dr_q <= '0;
		end else if (cmd.div_step && !stat.div_done) begin
			dn_q <= dn_q << 1;
			dq_q <= {dq_q[NUM_W-2:0], d_ge};
			dr_q <= d_ge ? d_diff[DATA_W-1:0] : d_shift[DATA_W-1:0];
		end
	end

endmodule

@@ design/rpn_stack_calculator.sv @@
// Push, drop, add, subtract and the unused codes pass the read and execute
// states before the registered done strobe; unless its checks fail, multiply
// also steps through four 32x32 partial products and divide through the
// one-bit-per-cycle divider. A new request is taken in the cycle the strobe is
// shown; the receiver cannot stall. Reset clears the sequencer and the stack
// depth; stack memory is not cleared: unwritten entries never reach the result.
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse Polish operand stack with a saturating signed fixed-point
// arithmetic unit.
// ----------------------------------------------------------------------------
module rpn_stack_calculator import rpn_pkg::*; #(
	parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  request_t request,
	output logic     busy,
	output logic     done,
	output result_t  result
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	rpn_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	rpn_dp #(
		.STACK_DEPTH   (STACK_DEPTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.stat    (stat),
		.done    (done),
		.result  (result)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while the sequencer is busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted request did not start work");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (STACK_DEPTH < 128) && (result.depth == '0)) |-> (result.top_value == '0))
		else $error("empty stack reported a non-zero top");

endmodule
